// ===== src/fsa_pkg.sv =====
package fsa_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int MAG_WIDTH = 64;
   localparam int CNT_WIDTH = 7;

   typedef struct packed {
      logic signed [31:0] numerator;
      logic signed [31:0] denominator;
      logic               restart;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sum_numerator;
      logic signed [31:0] sum_denominator;
      logic               skipped;
      logic               overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_COMB,
      ST_GCD_CHK,
      ST_MOD,
      ST_DIVN,
      ST_DIVD,
      ST_COMMIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic comb;
      logic mod_start;
      logic mod_step;
      logic gcd_swap;
      logic divn_start;
      logic divd_start;
      logic div_step;
      logic divn_done;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic b_zero;
      logic cnt_last;
   } sts_type;

endpackage

// ===== src/fsa_ctrl.sv =====
module fsa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  fsa_pkg::sts_type  sts,
   output fsa_pkg::cmd_type  cmd
);
   import fsa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MUL1;
         ST_MUL1:    state_in = sts.skip ? ST_OUT : ST_MUL2;
         ST_MUL2:    state_in = ST_COMB;
         ST_COMB:    state_in = ST_GCD_CHK;
         ST_GCD_CHK: state_in = sts.b_zero ? ST_DIVN : ST_MOD;
         ST_MOD:     if (sts.cnt_last) state_in = ST_GCD_CHK;
         ST_DIVN:    if (sts.cnt_last) state_in = ST_DIVD;
         ST_DIVD:    if (sts.cnt_last) state_in = ST_COMMIT;
         ST_COMMIT:  state_in = ST_OUT;
         ST_OUT:     if (!rsp_stall) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         ST_MUL1: cmd.mul1 = 1'b1;
         ST_MUL2: cmd.mul2 = 1'b1;
         ST_COMB: cmd.comb = 1'b1;
         ST_GCD_CHK: begin
            cmd.mod_start = !sts.b_zero;
            cmd.divn_start = sts.b_zero;
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            cmd.gcd_swap = sts.cnt_last;
         end
         ST_DIVN: begin
            cmd.div_step = 1'b1;
            cmd.divn_done = sts.cnt_last;
            cmd.divd_start = sts.cnt_last;
         end
         ST_DIVD: cmd.div_step = 1'b1;
         ST_COMMIT: cmd.commit = 1'b1;
         ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== src/fsa_dp.sv =====
module fsa_dp (
   input  logic              clock,
   input  logic              reset,
   input  fsa_pkg::req_type  req_data,
   input  fsa_pkg::cmd_type  cmd,
   output fsa_pkg::sts_type  sts,
   output fsa_pkg::rsp_type  rsp_data
);
   import fsa_pkg::*;

   localparam logic [MAG_WIDTH-1:0] LIM = MAG_WIDTH'(1) << (VALUE_WIDTH - 1);

   // running sum
   logic signed [31:0] acc_n_ff, acc_d_ff;
   logic               ovf_ff, skip_ff;
   // item operands
   logic [31:0]        nm_ff, dm_ff, ad_ff;
   logic               n_neg_ff, d_neg_ff, an_neg_ff, ad_neg_ff;
   logic [MAG_WIDTH-1:0] m1_ff, m2_ff;
   logic               s1_ff;
   logic [MAG_WIDTH-1:0] num_ff, den_ff;
   logic               num_neg_ff, den_neg_ff;
   // gcd / divider
   logic [MAG_WIDTH-1:0] a_ff, b_ff;
   logic [MAG_WIDTH-1:0] rem_ff, quo_ff, dvs_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic [MAG_WIDTH-1:0] qn_ff;

   logic [MAG_WIDTH:0]   trial;
   logic [MAG_WIDTH-1:0] shl_rem;
   logic                 fit_n, fit_d;
   logic [31:0]          acc_n_mag, acc_d_mag;

   assign acc_n_mag = acc_n_ff[31] ? 32'(-acc_n_ff) : acc_n_ff;
   assign acc_d_mag = acc_d_ff[31] ? 32'(-acc_d_ff) : acc_d_ff;

   // restoring divide, one quotient bit per cycle
   assign shl_rem = {rem_ff[MAG_WIDTH-2:0], quo_ff[MAG_WIDTH-1]};
   assign trial = {rem_ff, quo_ff[MAG_WIDTH-1]} - {1'b0, dvs_ff};

   assign fit_n = num_neg_ff ? (qn_ff <= LIM) : (qn_ff < LIM);
   assign fit_d = den_neg_ff ? (quo_ff <= LIM) : (quo_ff < LIM);

   assign sts.skip = skip_ff;
   assign sts.b_zero = (b_ff == '0);
   assign sts.cnt_last = (cnt_ff == CNT_WIDTH'(MAG_WIDTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_n_ff <= '0;
         acc_d_ff <= 32'sd1;
         ovf_ff <= 1'b0;
      end else begin
         if (cmd.load && req_data.restart) begin
            acc_n_ff <= '0;
            acc_d_ff <= 32'sd1;
            ovf_ff <= 1'b0;
         end else if (cmd.commit) begin
            if (fit_n && fit_d) begin
               acc_n_ff <= num_neg_ff ? 32'(-qn_ff) : qn_ff[31:0];
               acc_d_ff <= den_neg_ff ? 32'(-quo_ff) : quo_ff[31:0];
            end else begin
               ovf_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         nm_ff <= req_data.numerator[31] ? 32'(-req_data.numerator) : req_data.numerator;
         dm_ff <= req_data.denominator[31] ? 32'(-req_data.denominator)
                                          : req_data.denominator;
         n_neg_ff <= req_data.numerator[31];
         d_neg_ff <= req_data.denominator[31];
         skip_ff <= (req_data.denominator == '0);
      end
      if (cmd.mul1) begin
         ad_ff <= acc_d_mag;
         an_neg_ff <= acc_n_ff[31];
         ad_neg_ff <= acc_d_ff[31];
         m1_ff <= MAG_WIDTH'(acc_n_mag) * MAG_WIDTH'(dm_ff);
      end
      if (cmd.mul2) begin
         m2_ff <= MAG_WIDTH'(nm_ff) * MAG_WIDTH'(ad_ff);
         den_ff <= MAG_WIDTH'(ad_ff) * MAG_WIDTH'(dm_ff);
         s1_ff <= (an_neg_ff != d_neg_ff) && (m1_ff != '0);
         den_neg_ff <= ad_neg_ff != d_neg_ff;
      end
      if (cmd.comb) begin
         if (s1_ff == ((n_neg_ff != ad_neg_ff) && (m2_ff != '0))) begin
            num_ff <= m1_ff + m2_ff;
            num_neg_ff <= s1_ff && (m1_ff + m2_ff != '0);
         end else if (m1_ff >= m2_ff) begin
            num_ff <= m1_ff - m2_ff;
            num_neg_ff <= s1_ff && (m1_ff != m2_ff);
         end else begin
            num_ff <= m2_ff - m1_ff;
            num_neg_ff <= !s1_ff;
         end
      end
      if (cmd.comb) begin
         a_ff <= (s1_ff == ((n_neg_ff != ad_neg_ff) && (m2_ff != '0))) ? m1_ff + m2_ff
               : (m1_ff >= m2_ff) ? m1_ff - m2_ff : m2_ff - m1_ff;
         b_ff <= den_ff;
      end
      // a mod b, then swap
      if (cmd.mod_start) begin
         rem_ff <= '0;
         quo_ff <= a_ff;
         dvs_ff <= b_ff;
         cnt_ff <= '0;
      end else if (cmd.divn_start) begin
         rem_ff <= '0;
         quo_ff <= num_ff;
         dvs_ff <= (a_ff == '0) ? MAG_WIDTH'(1) : a_ff;
         cnt_ff <= '0;
      end else if (cmd.divd_start) begin
         rem_ff <= '0;
         quo_ff <= den_ff;
         cnt_ff <= '0;
      end else if (cmd.mod_step || cmd.div_step) begin
         if (!trial[MAG_WIDTH]) begin
            rem_ff <= trial[MAG_WIDTH-1:0];
            quo_ff <= {quo_ff[MAG_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff <= shl_rem;
            quo_ff <= {quo_ff[MAG_WIDTH-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + CNT_WIDTH'(1);
      end
      if (cmd.gcd_swap) begin
         a_ff <= b_ff;
         b_ff <= trial[MAG_WIDTH] ? shl_rem : trial[MAG_WIDTH-1:0];
      end
      if (cmd.divn_done) begin
         qn_ff <= {quo_ff[MAG_WIDTH-2:0], !trial[MAG_WIDTH]};
      end
   end

   assign rsp_data.sum_numerator = acc_n_ff;
   assign rsp_data.sum_denominator = acc_d_ff;
   assign rsp_data.skipped = skip_ff;
   assign rsp_data.overflow = ovf_ff;

endmodule

// ===== src/fraction_sum_accumulator.sv =====
// Order: a skipped item goes from MUL1 straight to output; otherwise setup (MUL1, MUL2, COMB,
// GCD_CHK), one 64-bit mod per Euclid step, the two exact divisions, commit (one 64-bit restoring
// divider, 1 bit/cycle).
// Throughput: one item at a time; next item accepted the cycle after the result is taken.
// Reset (synchronous, active high): sum 0/1, overflow cleared, controller idle.
module fraction_sum_accumulator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fsa_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fsa_pkg::rsp_type  rsp_data
);
   import fsa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: load, two multiply steps, Euclid loop, two divides, commit, output
   fsa_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd)
   );

   // operand registers, multiplier, shared divider, running sum
   fsa_dp u_dp (
      .clock(clock), .reset(reset),
      .req_data(req_data), .cmd(cmd), .sts(sts), .rsp_data(rsp_data)
   );

   // the sum denominator is never zero while rsp_valid
   a_den_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.sum_denominator != '0) else $error("zero denominator");

   // no new item taken while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept during output");

   // result held while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data)) else $error("rsp changed");

endmodule
